>>> hdl/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared types, step addresses and the microcode program of the
// trial-division prime test sequencer.
// ----------------------------------------------------------------------------
package tdpt_pkg;

    // jump conditions tested by a microword
    typedef enum logic [3:0] {
        C_NO_IN_XFER = 4'd0,  // no input transfer this cycle
        C_LT2        = 4'd1,  // number below two
        C_LT4        = 4'd2,  // number below four
        C_EVEN       = 4'd3,  // number even
        C_SQ_GT      = 4'd4,  // divisor squared above number
        C_DIV_MORE   = 4'd5,  // remainder bits still to go
        C_REM_ZERO   = 4'd6,  // remainder is zero
        C_ALWAYS     = 4'd7,  // unconditional jump
        C_OUT_BUSY   = 4'd8   // output register still occupied
    } t_cond;

    typedef logic [3:0] t_upc;

    // one control word: jump to target when cond holds, else next step
    typedef struct packed {
        t_cond cond;
        t_upc  target;
        logic  ready;     // accept an input item
        logic  div_init;  // start a remainder pass
        logic  div_step;  // one restoring remainder step
        logic  advance;   // next odd divisor and its square
        logic  set_res;   // write result to output register
        logic  res_val;   // result value to write
    } t_uword;

    localparam int UROM_DEPTH = 16;

    // step addresses
    localparam t_upc S_IDLE     = 4'd0;
    localparam t_upc S_LT2      = 4'd1;
    localparam t_upc S_LT4      = 4'd2;
    localparam t_upc S_EVEN     = 4'd3;
    localparam t_upc S_TEST     = 4'd4;
    localparam t_upc S_DIV      = 4'd5;
    localparam t_upc S_REM      = 4'd6;
    localparam t_upc S_NEXT     = 4'd7;
    localparam t_upc S_RES0     = 4'd8;
    localparam t_upc S_RES0_END = 4'd9;
    localparam t_upc S_RES1     = 4'd10;
    localparam t_upc S_RES1_END = 4'd11;

    // unused addresses fall back to idle
    localparam t_uword W_SPARE = '{C_ALWAYS, S_IDLE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};

    // the program
    localparam t_uword C_UROM [0:UROM_DEPTH-1] = '{
        //  cond          target  rdy   init  step  adv   set   val
        '{C_NO_IN_XFER, S_IDLE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, // idle
        '{C_LT2,        S_RES0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, // zero, one
        '{C_LT4,        S_RES1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, // two, three
        '{C_EVEN,       S_RES0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, // even
        '{C_SQ_GT,      S_RES1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}, // bound test
        '{C_DIV_MORE,   S_DIV,  1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}, // remainder
        '{C_REM_ZERO,   S_RES0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, // divides
        '{C_ALWAYS,     S_TEST, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0}, // next divisor
        '{C_OUT_BUSY,   S_RES0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0}, // not prime
        '{C_ALWAYS,     S_IDLE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{C_OUT_BUSY,   S_RES1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1}, // prime
        '{C_ALWAYS,     S_IDLE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        W_SPARE,
        W_SPARE,
        W_SPARE,
        W_SPARE
    };

endpackage

>>> hdl/trial_division_prime_test_top.sv
// ----------------------------------------------------------------------------
// trial_division_prime_test_top
// Reports whether an unsigned integer is prime, by trial division under a
// microcoded sequencer.
// ----------------------------------------------------------------------------
// One number in, one is_prime flag out. Items are handled one at a time; the
// next number is taken as soon as the sequencer is back in idle, even while
// the previous flag still waits in the output register. Zero and one are
// settled by the first check, two, three and even numbers by the checks that
// follow; otherwise each odd divisor d = 3, 5, 7, ... with d*d <= n gets a
// full pass of the bit-serial restoring remainder unit (one quotient bit per
// cycle). A prime near 2**31 at the default width tries about 23170
// divisors. The divisor square is kept by running addition, so no
// multiplier is used.
module trial_division_prime_test_top
    import tdpt_pkg::*;
#(
    parameter int NUM_WIDTH = 31
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // slave side
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [((NUM_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,  // [NUM_WIDTH-1:0] number
    // master side
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    output logic [7:0]                   o_m_axis_tdata     // [0] is_prime
);

    localparam int SQ_W  = NUM_WIDTH + 1;
    localparam int CNT_W = $clog2(NUM_WIDTH);

    t_upc                 r_pc, n_pc;
    t_uword               uword;
    logic                 cond_true;
    logic                 in_xfer;

    logic [NUM_WIDTH-1:0] r_n;
    logic [NUM_WIDTH-1:0] r_d;
    logic [SQ_W-1:0]      r_sq;
    logic [NUM_WIDTH-1:0] r_rem;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_out_valid;
    logic                 r_out_bit;

    logic [SQ_W-1:0]      trial;
    logic [SQ_W-1:0]      diff;
    logic [NUM_WIDTH-1:0] n_rem;

    // microword fetch, no transfer taken while in reset
    assign uword           = C_UROM[r_pc];
    assign o_s_axis_tready = uword.ready & i_rst_n;
    assign in_xfer         = i_s_axis_tvalid & o_s_axis_tready;

    // condition select
    always_comb begin
        case (uword.cond)
            C_NO_IN_XFER: cond_true = !in_xfer;
            C_LT2:        cond_true = (r_n < NUM_WIDTH'(2));
            C_LT4:        cond_true = (r_n < NUM_WIDTH'(4));
            C_EVEN:       cond_true = !r_n[0];
            C_SQ_GT:      cond_true = (r_sq > {1'b0, r_n});
            C_DIV_MORE:   cond_true = (r_cnt != '0);
            C_REM_ZERO:   cond_true = (r_rem == '0);
            C_ALWAYS:     cond_true = 1'b1;
            C_OUT_BUSY:   cond_true = r_out_valid;
            default:      cond_true = 1'b1;
        endcase
    end

    // step counter: jump or fall through
    always_comb begin
        if (cond_true) begin
            n_pc = uword.target;
        end else begin
            n_pc = r_pc + t_upc'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    // restoring remainder step: shift in one bit of n, subtract if it fits
    assign trial = {r_rem, r_n[r_cnt]};
    assign diff  = trial - {1'b0, r_d};
    always_comb begin
        if (trial >= {1'b0, r_d}) begin
            n_rem = diff[NUM_WIDTH-1:0];
        end else begin
            n_rem = trial[NUM_WIDTH-1:0];
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_n  <= i_s_axis_tdata[NUM_WIDTH-1:0];
            r_d  <= NUM_WIDTH'(3);
            r_sq <= SQ_W'(9);
        end
        if (uword.div_init) begin
            r_rem <= '0;
            r_cnt <= CNT_W'(NUM_WIDTH - 1);
        end
        if (uword.div_step) begin
            r_rem <= n_rem;
            r_cnt <= r_cnt - CNT_W'(1);
        end
        // (d+2)^2 = d^2 + 4d + 4
        if (uword.advance) begin
            r_d  <= r_d + NUM_WIDTH'(2);
            r_sq <= r_sq + SQ_W'({r_d, 2'b00}) + SQ_W'(4);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (uword.set_res && !r_out_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (uword.set_res && !r_out_valid) begin
            r_out_bit <= uword.res_val;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'b0, r_out_bit};

    // a transfer in always starts the small-value checks
    a_xfer_to_checks : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_pc == S_LT2))
        else $error("sequencer did not leave idle after input transfer");

    // only odd divisors reach the bound test
    a_odd_divisor : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == S_TEST) |-> r_d[0])
        else $error("even divisor at bound test");

    // running square tracks the divisor
    a_square : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == S_TEST) |-> (r_sq == SQ_W'(SQ_W'(r_d) * SQ_W'(r_d))))
        else $error("divisor square out of step");

    // partial remainder stays below the divisor
    a_rem_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == S_DIV) |-> (r_rem < r_d))
        else $error("partial remainder not below divisor");

    // a pending result is held until taken; results go only into an empty register
    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |=> r_out_valid)
        else $error("pending result dropped");

endmodule
